// ----- hw/rtl/tnem_pkg.sv -----
// ----------------------------------------------------------------------------
// tnem_pkg
// shared types and constants of the trigger number event merger
// ----------------------------------------------------------------------------
package tnem_pkg;

    // fixed field widths
    localparam int TRIG_W = 32;
    localparam int TS_W   = 64;
    localparam int HDL_W  = 16;
    localparam int DROP_W = 11;
    localparam int WARN_W = 11;
    localparam int MODE_W = 2;

    // input word modes
    localparam logic [MODE_W-1:0] MODE_FIRST  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SECOND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    // register map
    localparam logic REG_WARN_LEVEL = 1'b0;
    localparam logic [WARN_W-1:0] WARN_RESET = 11'd1000;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MERGE,
        ST_EMIT
    } t_state;

    // queue control
    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } t_q_ctrl;

endpackage

// ----- hw/rtl/tnem_queue.sv -----
// ----------------------------------------------------------------------------
// tnem_queue
// circular queue in a synchronous memory, head entry always read out
// ----------------------------------------------------------------------------
module tnem_queue #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tnem_pkg::t_q_ctrl             i_ctrl,
    input  logic [DATA_W-1:0]             i_wdata,
    output logic [DATA_W-1:0]             o_rdata,
    output logic [$clog2(DEPTH+1)-1:0]    o_count,
    output logic                          o_full
);
    import tnem_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [AW-1:0]     r_head, n_head;
    logic [CW-1:0]     r_count, n_count;
    logic [DATA_W-1:0] r_rdata;
    logic [SW-1:0]     tail_sum;
    logic [AW-1:0]     tail;
    logic [AW-1:0]     head_inc;
    logic              push_ok;

    assign o_full  = (r_count == CW'(DEPTH));
    assign push_ok = i_ctrl.push && !o_full && !i_ctrl.clear;

    // tail = (head + count) mod depth, sum stays below twice the depth
    assign tail_sum = SW'(r_head) + SW'(r_count);
    assign tail     = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
    assign head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_ctrl.clear) begin
            n_head  = '0;
            n_count = '0;
        end else begin
            if (push_ok) begin
                n_count = n_count + CW'(1);
            end
            if (i_ctrl.pop) begin
                n_head  = head_inc;
                n_count = n_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // memory: one write port at the tail, one read port on the next head
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            mem[tail] <= i_wdata;
        end
        r_rdata <= mem[n_head];
    end

    assign o_rdata = r_rdata;
    assign o_count = r_count;

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.pop |-> (r_count != '0))
        else $error("pop from empty queue");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.clear |=> (r_count == '0))
        else $error("clear left entries");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_ok && !i_ctrl.pop) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("push did not grow queue");

endmodule

// ----- hw/rtl/trigger_number_event_merger_top.sv -----
// ----------------------------------------------------------------------------
// trigger_number_event_merger_top
// merges first-source and second-source event records by trigger number
// ----------------------------------------------------------------------------
// Each input word pushes one event record into the first or second source
// queue, unless that queue is full, or clears both queues at start of run.
// The block then walks the queue heads, dropping the one with the lower
// trigger number, until one queue is empty; equal trigger numbers pop both
// heads and give a merged record. One output word is produced for every
// input word, which passes the accept state, the compare loop (one head
// comparison for each drop and the match) and the emit state. The loop
// makes one comparison per cycle, dropping one head or both on a match, as
// each queue memory has a single read port that always presents the entry
// at the next head. The output word sits in a register, so the next input
// word is taken while it still waits. The queue memories are not cleared
// after reset; occupancy counters alone track what is valid.
module trigger_number_event_merger_top #(
    parameter int QUEUE_DEPTH = 1024,
    parameter int HANDLE_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input channel
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [tnem_pkg::MODE_W-1:0]  i_mode,
    input  logic [tnem_pkg::TRIG_W-1:0]  i_trigger_number,
    input  logic [tnem_pkg::TS_W-1:0]    i_ts_begin,
    input  logic [tnem_pkg::TS_W-1:0]    i_ts_end,
    input  logic [tnem_pkg::HDL_W-1:0]   i_event_handle,
    // output channel
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_matched,
    output logic [tnem_pkg::TRIG_W-1:0]  o_out_trigger,
    output logic [tnem_pkg::TS_W-1:0]    o_out_ts_begin,
    output logic [tnem_pkg::TS_W-1:0]    o_out_ts_end,
    output logic [tnem_pkg::HDL_W-1:0]   o_first_handle,
    output logic [tnem_pkg::HDL_W-1:0]   o_second_handle,
    output logic [tnem_pkg::DROP_W-1:0]  o_dropped_first,
    output logic [tnem_pkg::DROP_W-1:0]  o_dropped_second,
    output logic                         o_above_warn_level,
    output logic                         o_rejected_full,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import tnem_pkg::*;

    // stored handle bits, the port carries at most HDL_W of them
    localparam int HK = (HANDLE_BITS < HDL_W) ? HANDLE_BITS : HDL_W;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int MW = (CW > WARN_W) ? CW : WARN_W;
    // first record layout: trigger | begin | end | handle
    localparam int W1 = TRIG_W + 2 * TS_W + HK;
    // second record layout: trigger | handle
    localparam int W2 = TRIG_W + HK;

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    logic [WARN_W-1:0] r_warn;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_WARN_LEVEL);
    assign prdata = (paddr[2] == REG_WARN_LEVEL) ? 32'(r_warn) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warn <= WARN_RESET;
        end else if (cfg_wr) begin
            r_warn <= pwdata[WARN_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // queues
    // ------------------------------------------------------------------
    t_q_ctrl         q1_ctrl, q2_ctrl;
    logic [W1-1:0]   q1_wdata, q1_rdata;
    logic [W2-1:0]   q2_wdata, q2_rdata;
    logic [CW-1:0]   q1_count, q2_count;
    logic            q1_full, q2_full;

    assign q1_wdata = {i_trigger_number, i_ts_begin, i_ts_end, i_event_handle[HK-1:0]};
    assign q2_wdata = {i_trigger_number, i_event_handle[HK-1:0]};

    tnem_queue #(
        .DEPTH  (QUEUE_DEPTH),
        .DATA_W (W1)
    ) u_first_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (q1_ctrl),
        .i_wdata (q1_wdata),
        .o_rdata (q1_rdata),
        .o_count (q1_count),
        .o_full  (q1_full)
    );

    tnem_queue #(
        .DEPTH  (QUEUE_DEPTH),
        .DATA_W (W2)
    ) u_second_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (q2_ctrl),
        .i_wdata (q2_wdata),
        .o_rdata (q2_rdata),
        .o_count (q2_count),
        .o_full  (q2_full)
    );

    // head fields straight from the memory read registers
    logic [TRIG_W-1:0] h1_trig, h2_trig;
    logic [TS_W-1:0]   h1_tsb, h1_tse;
    logic [HK-1:0]     h1_hdl, h2_hdl;

    assign h1_trig = q1_rdata[W1-1 -: TRIG_W];
    assign h1_tsb  = q1_rdata[HK + 2*TS_W - 1 -: TS_W];
    assign h1_tse  = q1_rdata[HK + TS_W - 1 -: TS_W];
    assign h1_hdl  = q1_rdata[HK-1:0];
    assign h2_trig = q2_rdata[W2-1 -: TRIG_W];
    assign h2_hdl  = q2_rdata[HK-1:0];

    // ------------------------------------------------------------------
    // pushed word, kept for the compare loop
    // ------------------------------------------------------------------
    // between words one queue is always empty, so after a push only the
    // other queue's heads are compared against the pushed record, which
    // is therefore taken from these registers instead of the memory
    logic              r_side;     // 1 when the word went to the second queue
    logic [TRIG_W-1:0] r_trig;
    logic [TS_W-1:0]   r_tsb, r_tse;
    logic [HK-1:0]     r_hdl;

    // ------------------------------------------------------------------
    // compare
    // ------------------------------------------------------------------
    logic [TRIG_W-1:0] cmp_t1, cmp_t2;
    logic              busy, t_lt, t_gt, t_eq;

    assign cmp_t1 = r_side ? h1_trig : r_trig;
    assign cmp_t2 = r_side ? r_trig : h2_trig;
    assign busy   = (q1_count != '0) && (q2_count != '0);
    assign t_lt   = cmp_t1 < cmp_t2;
    assign t_gt   = cmp_t1 > cmp_t2;
    assign t_eq   = cmp_t1 == cmp_t2;

    // ------------------------------------------------------------------
    // control
    // ------------------------------------------------------------------
    t_state r_state, n_state;
    logic   out_free;
    logic   s_accept, s_match, s_drop1, s_drop2, s_load;

    assign out_free = !o_valid || i_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_valid) n_state = ST_MERGE;
            ST_MERGE: if (!busy) n_state = ST_EMIT;
            ST_EMIT:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready  = 1'b0;
        s_accept = 1'b0;
        s_match  = 1'b0;
        s_drop1  = 1'b0;
        s_drop2  = 1'b0;
        s_load   = 1'b0;
        q1_ctrl  = '0;
        q2_ctrl  = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready  = 1'b1;
                s_accept = i_valid;
                q1_ctrl.clear = i_valid && (i_mode == MODE_CLEAR);
                q2_ctrl.clear = i_valid && (i_mode == MODE_CLEAR);
                q1_ctrl.push  = i_valid && (i_mode == MODE_FIRST);
                q2_ctrl.push  = i_valid && (i_mode == MODE_SECOND);
            end
            ST_MERGE: begin
                // lower head is dropped, equal heads merge
                s_match     = busy && t_eq;
                s_drop1     = busy && t_lt;
                s_drop2     = busy && t_gt;
                q1_ctrl.pop = busy && !t_gt;
                q2_ctrl.pop = busy && !t_lt;
            end
            ST_EMIT: begin
                s_load = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // per-word results
    // ------------------------------------------------------------------
    logic              r_acc_match, r_acc_rej;
    logic [TRIG_W-1:0] r_acc_trig;
    logic [TS_W-1:0]   r_acc_tsb, r_acc_tse;
    logic [HK-1:0]     r_acc_h1, r_acc_h2;
    logic [DROP_W-1:0] r_acc_d1, r_acc_d2;
    logic              warn_now;

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_side      <= (i_mode == MODE_SECOND);
            r_trig      <= i_trigger_number;
            r_tsb       <= i_ts_begin;
            r_tse       <= i_ts_end;
            r_hdl       <= i_event_handle[HK-1:0];
            r_acc_rej   <= ((i_mode == MODE_FIRST) && q1_full)
                        || ((i_mode == MODE_SECOND) && q2_full);
            r_acc_match <= 1'b0;
            r_acc_trig  <= '0;
            r_acc_tsb   <= '0;
            r_acc_tse   <= '0;
            r_acc_h1    <= '0;
            r_acc_h2    <= '0;
            r_acc_d1    <= '0;
            r_acc_d2    <= '0;
        end else begin
            if (s_match) begin
                // record from the first queue's head or the pushed word
                r_acc_match <= 1'b1;
                r_acc_trig  <= cmp_t1;
                r_acc_tsb   <= r_side ? h1_tsb : r_tsb;
                r_acc_tse   <= r_side ? h1_tse : r_tse;
                r_acc_h1    <= r_side ? h1_hdl : r_hdl;
                r_acc_h2    <= r_side ? r_hdl : h2_hdl;
            end
            if (s_drop1) begin
                r_acc_d1 <= r_acc_d1 + DROP_W'(1);
            end
            if (s_drop2) begin
                r_acc_d2 <= r_acc_d2 + DROP_W'(1);
            end
        end
    end

    assign warn_now = (MW'(q1_count) > MW'(r_warn)) || (MW'(q2_count) > MW'(r_warn));

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic r_o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s_load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_load) begin
            o_matched          <= r_acc_match;
            o_out_trigger      <= r_acc_trig;
            o_out_ts_begin     <= r_acc_tsb;
            o_out_ts_end       <= r_acc_tse;
            o_first_handle     <= HDL_W'(r_acc_h1);
            o_second_handle    <= HDL_W'(r_acc_h2);
            o_dropped_first    <= r_acc_d1;
            o_dropped_second   <= r_acc_d2;
            o_above_warn_level <= warn_now;
            o_rejected_full    <= r_acc_rej;
        end
    end

    assign o_valid = r_o_valid;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_one_queue_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> ((q1_count == '0) || (q2_count == '0)))
        else $error("both queues hold records between words");

    a_accept_to_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_state == ST_MERGE))
        else $error("accepted word did not start the compare loop");

    a_emit_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && o_valid && !i_ready) |=> (r_state == ST_EMIT))
        else $error("result overwrote a waiting output word");

endmodule
